/* src/gcd_pkg.sv */
// Types and constants of the glyph column decompressor.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package gcd_pkg;

  localparam int unsigned GLYPH_WIDTH = 15;
  localparam int unsigned DICT_DEPTH  = 8;
  localparam int unsigned COL_W       = 15;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned DICT_AW     = 3;

  localparam logic [IDX_W-1:0] COL_LAST   = 4'd14;
  localparam logic [IDX_W-1:0] COL_END    = 4'd15;
  localparam logic [IDX_W-1:0] COL_MIRROR = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       glyph_start;
  } gcd_in_t;

  typedef struct packed {
    logic [COL_W-1:0] column_bits;
    logic [IDX_W-1:0] column_index;
    logic             last_column;
  } gcd_out_t;

  typedef enum logic [1:0] {
    OP_ZERO   = 2'd0,
    OP_RAW    = 2'd1,
    OP_DICT   = 2'd2,
    OP_MIRROR = 2'd3
  } op_kind_e;

endpackage

`default_nettype wire

/* src/gcd_if.sv */
// Valid/ready channel interfaces for compressed bytes and decoded columns.
// Depends on gcd_pkg for the payload types.
`default_nettype none

interface gcd_in_if;
  logic            valid;
  logic            ready;
  gcd_pkg::gcd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gcd_out_if;
  logic             valid;
  logic             ready;
  gcd_pkg::gcd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/glyph_column_decompressor.sv */
// Glyph column decompressor: byte stream in, 15 pixel columns per glyph out.
// Depends on gcd_pkg and on the channel interfaces in gcd_if.sv.
//
// in_i carries one byte per item: a header (glyph_start = 1) or a payload
// byte. out_o carries one column per item, in column order, with its index
// and a flag on column 14. A byte is held in an input register and decoded
// one nibble per cycle while the output flows; after a header its bar columns
// go out one per cycle while the output flows and input is held.
// When the payload runs out or the last decoded column is reached, the
// remaining columns (zero or mirror) go out one per cycle in the same way.
// The dictionary and the column store are synchronous memories read when a
// column is issued; a column passes from the input register through the
// column stage to the output register, and one from the high nibble or a
// bar column is issued only after the low nibble or the header is decoded.
// At most one column leaves per cycle.
// Reset clears the control state and marks every dictionary entry as zero;
// no clearing pass is needed. When out_o stalls, the column stage and the
// output register hold, and input stops once a held byte needs to issue.
`default_nettype none

module glyph_column_decompressor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gcd_in_if.sink    in_i,
  gcd_out_if.source out_o
);
  import gcd_pkg::*;

  logic [COL_W-1:0] dict_mem [DICT_DEPTH];
  logic [COL_W-1:0] emit_mem [8];

  logic                 pend_q, pend_d;
  logic                 hdr_q, hdr_d;
  logic [7:0]           byte_q, byte_d;
  logic                 hi_q, hi_d;
  logic                 run_q, run_d;
  logic [IDX_W-1:0]     run_to_q, run_to_d;
  logic                 run_mir_q, run_mir_d;
  logic [2:0]           crop_q, crop_d;
  logic [4:0]           left_q, left_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [COL_W-1:0]     acc_q, acc_d;
  logic [DICT_AW-1:0]   slot_q, slot_d;
  logic                 done_q, done_d;
  logic [IDX_W-1:0]     next_q, next_d;
  logic [DICT_DEPTH-1:0] dvld_q;

  logic                 s2_v_q;
  op_kind_e             s2_kind_q;
  logic [COL_W-1:0]     s2_raw_q;
  logic [IDX_W-1:0]     s2_idx_q;
  logic [COL_W-1:0]     s2_dict_q;
  logic [COL_W-1:0]     s2_emit_q;
  logic [COL_W-1:0]     s2_bits;

  logic                 out_v_q;
  gcd_out_t             out_q;

  logic                 s2_adv, issue_ok;
  logic                 iss;
  op_kind_e             iss_kind;
  logic [COL_W-1:0]     iss_raw;
  logic [DICT_AW-1:0]   iss_daddr;
  logic [2:0]           iss_eaddr;
  logic                 dict_we;
  logic [COL_W-1:0]     acc_fin;
  logic                 byte_done;
  logic                 need_iss;
  logic [3:0]           nib;
  logic [IDX_W-1:0]     end_col, nxt, mir_col;
  logic                 in_rdy;

  assign s2_adv   = s2_v_q && (!out_v_q || out_o.ready);
  assign issue_ok = !s2_v_q || s2_adv;
  assign end_col  = COL_END - {1'b0, crop_q};
  assign nib      = hi_q ? byte_q[7:4] : byte_q[3:0];
  assign mir_col  = COL_LAST - next_q;
  assign acc_fin  = acc_q | {nib, 11'b0};
  assign need_iss = ((cnt_q == 2'd0) && nib[0]) || (cnt_q == 2'd3);
  assign nxt      = next_q + {3'b0, need_iss};

  always_comb begin
    pend_d    = pend_q;
    hdr_d     = hdr_q;
    byte_d    = byte_q;
    hi_d      = hi_q;
    run_d     = run_q;
    run_to_d  = run_to_q;
    run_mir_d = run_mir_q;
    crop_d    = crop_q;
    left_d    = left_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    slot_d    = slot_q;
    done_d    = done_q;
    next_d    = next_q;
    iss       = 1'b0;
    iss_kind  = OP_ZERO;
    iss_raw   = '0;
    iss_daddr = '0;
    iss_eaddr = mir_col[2:0];
    dict_we   = 1'b0;
    byte_done = 1'b0;

    if (run_q) begin
      if (issue_ok) begin
        iss    = 1'b1;
        next_d = next_q + 4'd1;
        if (run_mir_q && (next_q < end_col)) begin
          iss_kind = OP_MIRROR;
        end
        if ((next_q + 4'd1) == run_to_q) begin
          run_d = 1'b0;
        end
      end
    end else if (pend_q) begin
      if (hdr_q) begin
        byte_done = 1'b1;
        crop_d    = byte_q[7:5];
        left_d    = byte_q[4:0];
        next_d    = '0;
        slot_d    = '0;
        cnt_d     = '0;
        acc_d     = '0;
        done_d    = 1'b0;
        run_mir_d = 1'b0;
        if (byte_q[4:0] == 5'd0) begin
          run_d    = 1'b1;
          run_to_d = COL_END;
          done_d   = 1'b1;
        end else if (byte_q[7:5] != 3'd0) begin
          run_d    = 1'b1;
          run_to_d = {1'b0, byte_q[7:5]};
        end
      end else if (!hi_q && done_q) begin
        byte_done = 1'b1;
        if (left_q != 5'd0) begin
          left_d = left_q - 5'd1;
        end
      end else if (!need_iss || issue_ok) begin
        if (!hi_q && (left_q != 5'd0)) begin
          left_d = left_q - 5'd1;
        end
        next_d = nxt;
        case (cnt_q)
          2'd0: begin
            if (nib[0]) begin
              iss       = 1'b1;
              iss_kind  = dvld_q[nib[3:1]] ? OP_DICT : OP_ZERO;
              iss_daddr = nib[3:1];
            end else begin
              acc_d = {12'b0, nib[3:1]};
              cnt_d = 2'd1;
            end
          end
          2'd1: begin
            acc_d = acc_q | {8'b0, nib, 3'b0};
            cnt_d = 2'd2;
          end
          2'd2: begin
            acc_d = acc_q | {4'b0, nib, 7'b0};
            cnt_d = 2'd3;
          end
          default: begin
            iss      = 1'b1;
            iss_kind = OP_RAW;
            iss_raw  = acc_fin;
            dict_we  = 1'b1;
            slot_d   = slot_q + 3'd1;
            cnt_d    = 2'd0;
            acc_d    = '0;
          end
        endcase
        if ((nxt >= end_col) || (hi_q && (left_q == 5'd0))) begin
          byte_done = 1'b1;
          cnt_d     = 2'd0;
          acc_d     = '0;
          done_d    = 1'b1;
          if (nxt < COL_END) begin
            run_d     = 1'b1;
            run_to_d  = COL_END;
            run_mir_d = (nxt == COL_MIRROR);
          end
        end else if (!hi_q) begin
          hi_d = 1'b1;
        end else begin
          byte_done = 1'b1;
        end
      end
    end

    if (byte_done) begin
      pend_d = 1'b0;
      hi_d   = 1'b0;
    end

    in_rdy = !run_q && (!pend_q || byte_done);
    if (in_rdy && in_i.valid) begin
      pend_d = 1'b1;
      hdr_d  = in_i.data.glyph_start;
      byte_d = in_i.data.data_byte;
      hi_d   = 1'b0;
    end
  end

  always_comb begin
    case (s2_kind_q)
      OP_RAW:    s2_bits = s2_raw_q;
      OP_DICT:   s2_bits = s2_dict_q;
      OP_MIRROR: s2_bits = s2_emit_q;
      default:   s2_bits = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      hdr_q     <= 1'b0;
      hi_q      <= 1'b0;
      run_q     <= 1'b0;
      run_to_q  <= '0;
      run_mir_q <= 1'b0;
      crop_q    <= '0;
      left_q    <= '0;
      cnt_q     <= '0;
      acc_q     <= '0;
      slot_q    <= '0;
      done_q    <= 1'b1;
      next_q    <= '0;
      dvld_q    <= '0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      hdr_q     <= hdr_d;
      hi_q      <= hi_d;
      run_q     <= run_d;
      run_to_q  <= run_to_d;
      run_mir_q <= run_mir_d;
      crop_q    <= crop_d;
      left_q    <= left_d;
      cnt_q     <= cnt_d;
      acc_q     <= acc_d;
      slot_q    <= slot_d;
      done_q    <= done_d;
      next_q    <= next_d;
      if (dict_we) begin
        dvld_q[slot_q] <= 1'b1;
      end
      if (iss) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (iss) begin
      s2_kind_q <= iss_kind;
      s2_raw_q  <= iss_raw;
      s2_idx_q  <= next_q;
    end
    if (s2_adv) begin
      out_q.column_bits  <= s2_bits;
      out_q.column_index <= s2_idx_q;
      out_q.last_column  <= (s2_idx_q == COL_LAST);
    end
  end

  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      dict_mem[slot_q] <= acc_fin;
    end
    if (iss) begin
      s2_dict_q <= dict_mem[iss_daddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && !s2_idx_q[3]) begin
      emit_mem[s2_idx_q[2:0]] <= s2_bits;
    end
    if (iss) begin
      s2_emit_q <= emit_mem[iss_eaddr];
    end
  end

  assign in_i.ready  = in_rdy;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

/* test/gcd_column_checker.sv */
// Column checker for the glyph column decompressor: watches both channels,
// decodes every accepted byte into the columns it must produce and compares.
// Depends on gcd_pkg and the channel interfaces in gcd_if.sv.
`default_nettype none

module gcd_column_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gcd_in_if         in_ch,
  gcd_out_if        out_ch,
  output int        fail_count_o,
  output int        pending_o
);
  import gcd_pkg::*;

  logic [COL_W-1:0]   dict_cols [DICT_DEPTH];
  logic [DICT_AW-1:0] dict_slot;
  logic [COL_W-1:0]   glyph_cols [8];
  logic [IDX_W-1:0]   col_ptr;
  logic [2:0]         crop;
  logic [4:0]         bytes_left;
  logic [1:0]         raw_cnt;
  logic [COL_W-1:0]   raw_acc;
  logic               glyph_done;
  gcd_out_t           columns_due [$];
  int                 mismatches = 0;

  function automatic int unsigned decode_limit();
    return GLYPH_WIDTH - crop;
  endfunction

  task automatic emit_column(input logic [COL_W-1:0] bits);
    if (col_ptr < 8) glyph_cols[col_ptr[2:0]] = bits;
    columns_due.push_back(gcd_out_t'{column_bits: bits, column_index: col_ptr,
                                     last_column: col_ptr == COL_LAST});
    col_ptr = col_ptr + 1'b1;
  endtask

  task automatic close_glyph();
    logic mirror;
    mirror = (col_ptr == COL_MIRROR);
    while (col_ptr < GLYPH_WIDTH) begin
      if (mirror && col_ptr < decode_limit()) begin
        emit_column(glyph_cols[3'(COL_LAST - col_ptr)]);
      end else begin
        emit_column('0);
      end
    end
    raw_cnt    = '0;
    raw_acc    = '0;
    glyph_done = 1'b1;
  endtask

  task automatic take_nibble(input logic [3:0] nib);
    logic [15:0] shifted;
    if (raw_cnt == 2'd0 && nib[0]) begin
      emit_column(dict_cols[nib[3:1]]);
    end else if (raw_cnt == 2'd0) begin
      raw_acc = COL_W'(nib[3:1]);
      raw_cnt = 2'd1;
    end else begin
      shifted = 16'(nib) << (4 * raw_cnt - 1);
      raw_acc = raw_acc | shifted[COL_W-1:0];
      if (raw_cnt == 2'd3) begin
        dict_cols[dict_slot] = raw_acc;
        dict_slot = dict_slot + 1'b1;
        emit_column(raw_acc);
        raw_cnt = '0;
        raw_acc = '0;
      end else begin
        raw_cnt = raw_cnt + 1'b1;
      end
    end
    if (col_ptr >= decode_limit()) close_glyph();
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic hdr);
    if (hdr) begin
      crop       = b[7:5];
      bytes_left = b[4:0];
      col_ptr    = '0;
      dict_slot  = '0;
      raw_cnt    = '0;
      raw_acc    = '0;
      glyph_done = 1'b0;
      if (bytes_left == 5'd0) begin
        while (col_ptr < GLYPH_WIDTH) emit_column('0);
        glyph_done = 1'b1;
      end else begin
        while (col_ptr < crop) emit_column('0);
      end
    end else begin
      if (bytes_left != 5'd0) bytes_left = bytes_left - 1'b1;
      if (!glyph_done) begin
        take_nibble(b[3:0]);
        if (!glyph_done) take_nibble(b[7:4]);
        if (!glyph_done && bytes_left == 5'd0) close_glyph();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gcd_out_t want;
    if (!rst_ni) begin
      foreach (dict_cols[i]) dict_cols[i] = '0;
      foreach (glyph_cols[i]) glyph_cols[i] = '0;
      dict_slot  = '0;
      col_ptr    = '0;
      crop       = '0;
      bytes_left = '0;
      raw_cnt    = '0;
      raw_acc    = '0;
      glyph_done = 1'b1;
      columns_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (columns_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected column: expected none, got %h/%0d/%b",
                   $time, out_ch.data.column_bits, out_ch.data.column_index,
                   out_ch.data.last_column);
        end else begin
          want = columns_due.pop_front();
          if (out_ch.data.column_bits !== want.column_bits ||
              out_ch.data.column_index !== want.column_index ||
              out_ch.data.last_column !== want.last_column) begin
            mismatches++;
            $display("%0t: column mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                     $time, want.column_bits, want.column_index, want.last_column,
                     out_ch.data.column_bits, out_ch.data.column_index,
                     out_ch.data.last_column);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        decode_byte(in_ch.data.data_byte, in_ch.data.glyph_start);
    end
    fail_count_o <= mismatches;
    pending_o    <= columns_due.size();
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
// Top of the glyph column decompressor test: clock, reset, byte stimulus,
// output back-pressure and the verdict. Depends on gcd_pkg, gcd_if.sv, the
// block itself and the column checker in gcd_column_checker.sv.
`default_nettype none

module testbench;
  import gcd_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned items_sent = 0;
  int          fail_count;
  int          columns_pending;

  gcd_in_if  in_ch ();
  gcd_out_if out_ch ();

  glyph_column_decompressor DUT (
    .clk_i,
    .rst_ni,
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  gcd_column_checker column_check (
    .clk_i,
    .rst_ni,
    .in_ch,
    .out_ch,
    .fail_count_o (fail_count),
    .pending_o    (columns_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic hdr);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= gcd_in_t'{data_byte: b, glyph_start: hdr};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_random_glyph();
    logic [3:0] nibs [$];
    int         crop;
    int         cols;
    int         len;
    int         sent;
    int         style;
    logic [7:0] b;
    crop  = $urandom_range(7);
    style = $urandom_range(9);
    if (style < 4) cols = 15 - 2 * crop;
    else if (style < 6) cols = 8 - crop;
    else cols = $urandom_range(15 - 2 * crop);
    repeat (cols) begin
      if ($urandom_range(2) == 0) begin
        nibs.push_back({3'($urandom_range(7)), 1'b0});
        repeat (3) nibs.push_back(4'($urandom));
      end else begin
        nibs.push_back({3'($urandom_range(7)), 1'b1});
      end
    end
    // pad with a raw start so the odd nibble is cut off at the payload end
    if (nibs.size() % 2 != 0) nibs.push_back({3'($urandom_range(7)), 1'b0});
    len = nibs.size() / 2;
    case (style)
      6: len = $urandom_range(len);
      7: len = len + $urandom_range(1, 3);
      9: begin
        nibs.delete();
        len = $urandom_range(31);
        repeat (2 * len) nibs.push_back(4'($urandom));
      end
      default: ;
    endcase
    if (len > 31) len = 31;
    sent = (style == 8) ? $urandom_range(len) : len;
    send_byte({3'(crop), 5'(len)}, 1'b1);
    for (int i = 0; i < sent; i++) begin
      b = (2 * i < nibs.size()) ? {nibs[2 * i + 1], nibs[2 * i]} : 8'($urandom);
      send_byte(b, 1'b0);
    end
    if ($urandom_range(7) == 0) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    int unsigned hold_left;
    logic        hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stray byte before any header
    send_byte(8'hA5, 1'b0);
    // empty payloads
    send_byte(8'h00, 1'b1);
    send_byte(8'hE0, 1'b1);
    // all-ones raw column, then zero fill
    send_byte(8'h02, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'hFF, 1'b0);
    // raw plus six dictionary columns, stop at column 8 and mirror
    send_byte(8'h25, 1'b1);
    send_byte(8'h42, 1'b0);
    send_byte(8'h86, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(8'h75, 1'b0);
    send_byte(8'hB9, 1'b0);
    // widest crop, extra payload, then a stray byte
    send_byte(8'hE3, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h77, 1'b0);
    // raw column cut short by the payload end
    send_byte(8'h01, 1'b1);
    send_byte(8'h20, 1'b0);
    // header abandons a long glyph
    send_byte(8'h1F, 1'b1);
    send_byte(8'h13, 1'b0);
    send_byte(8'h42, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);

    hold_req <= 1'b1;
    while (items_sent < 45) send_random_glyph();
    idle_pct = 66;
    while (items_sent < 65) send_random_glyph();
    idle_pct  = 0;
    stall_pct = 66;
    while (items_sent < 85) send_random_glyph();
    idle_pct  = 33;
    stall_pct = 33;
    while (items_sent < 100) send_random_glyph();

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (columns_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
